// ===== design/fecu_pkg.sv =====
// ----------------------------------------------------------------------------
// Fire effect cell update package
// Shared constants, palette tables and the front-end state type.
// ----------------------------------------------------------------------------
package fecu_pkg;

	localparam int DEF_HEAT_LEVELS = 13;
	localparam int DEF_MAX_CELLS   = 16384;

	localparam int HEAT_W    = 4;
	localparam int WIDTH_W   = 8;
	localparam int HEIGHT_W  = 7;
	localparam int ROW_W     = 6;
	localparam int RCNT_W    = 7;
	localparam int ROW_LIMIT = 64;
	localparam int JIT_W     = 2;

	localparam int IDX_W     = 14;
	localparam int GLYPH_W   = 14;
	localparam int COLOR_W   = 4;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 40;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [WIDTH_W-1:0]  RST_GRID_WIDTH  = 8'd80;
	localparam logic [HEIGHT_W-1:0] RST_GRID_HEIGHT = 7'd24;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd1;

	typedef enum logic [1:0] {
		FE_ROWS,
		FE_CLEAR,
		FE_RUN
	} fe_state_t;

	localparam logic [GLYPH_W-1:0] PAL_GLYPH [16] = '{
		14'd32,     14'h2591, 14'h2592, 14'h2593,
		14'h2588,   14'h2591, 14'h2592, 14'h2593,
		14'h2588,   14'h2591, 14'h2592, 14'h2593,
		14'h2588,   14'h2588, 14'h2588, 14'h2588
	};

	localparam logic [COLOR_W-1:0] PAL_FG [16] = '{
		4'd9, 4'd2, 4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4,
		4'd4, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
	};

	localparam logic [COLOR_W-1:0] PAL_BG [16] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd2, 4'd2,
		4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
	};

endpackage

// ===== design/fecu_queue.sv =====
// ----------------------------------------------------------------------------
// Fire effect cell update queue
// Small first-in first-out buffer between the scan front end and the back end.
// ----------------------------------------------------------------------------
module fecu_queue import fecu_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == NW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = store_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/fecu_front.sv =====
// ----------------------------------------------------------------------------
// Fire effect cell update front end
// Holds the grid registers, seeds the heat map after reset or a register
// write, walks the scan and turns each jitter item into a cell update.
// ----------------------------------------------------------------------------
module fecu_front import fecu_pkg::*; #(
	parameter  int MAX_CELLS = DEF_MAX_CELLS,
	localparam int AW        = $clog2(MAX_CELLS),
	localparam int EW        = 2 * AW + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [JIT_W-1:0]      jitter,
	output logic                  q_push,
	output logic [EW-1:0]         q_data,
	input  logic                  q_full,
	output logic                  clr_we,
	output logic [AW-1:0]         clr_addr,
	output logic                  clr_hot
);

	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int XW = (AW + 1 > WIDTH_W + 1) ? AW + 1 : WIDTH_W + 1;

	fe_state_t             state_q;
	fe_state_t             state_d;
	logic [WIDTH_W-1:0]    width_q;
	logic [HEIGHT_W-1:0]   height_q;
	logic [RCNT_W-1:0]     rcnt_q;
	logic [RCNT_W-1:0]     rows_q;
	logic [CW-1:0]         acc_q;
	logic [CW-1:0]         base_q;
	logic [AW-1:0]         cnt_q;
	logic [WIDTH_W-1:0]    col_q;
	logic [ROW_W-1:0]      row_q;
	logic [AW-1:0]         src_q;

	logic                  cfg_hit;
	logic [HEIGHT_W-1:0]   row_cap;
	logic [CW:0]           acc_nx;
	logic                  rows_done;
	logic                  clear_done;
	logic                  accept;
	logic [XW-1:0]         t_sum;
	logic [XW-1:0]         need;
	logic [AW-1:0]         dst;
	logic                  last_row;
	logic                  last_col;
	logic                  fend;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid &&
		(cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

	// Row count: the smaller of the height, the row limit and the number of
	// whole rows that fit in the map, found by adding the width once a cycle.
	assign row_cap    = (height_q > HEIGHT_W'(ROW_LIMIT)) ? HEIGHT_W'(ROW_LIMIT) : height_q;
	assign acc_nx     = (CW + 1)'(acc_q) + (CW + 1)'(width_q);
	assign rows_done  = (width_q == '0) || (rcnt_q == row_cap) ||
		(acc_nx > (CW + 1)'(MAX_CELLS));
	assign clear_done = (cnt_q == AW'(MAX_CELLS - 1));

	assign clr_we   = (state_q == FE_CLEAR);
	assign clr_addr = cnt_q;
	assign clr_hot  = (CW'(cnt_q) >= base_q) && (CW'(cnt_q) < acc_q);

	assign in_ready = (state_q == FE_RUN) && !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (rows_q >= RCNT_W'(2));

	// Destination falls back to cell zero when it would fall below cell zero.
	assign t_sum = XW'(src_q) + XW'(1);
	assign need  = XW'(jitter) + XW'(width_q);
	assign dst   = (t_sum < need) ? '0 : AW'(t_sum - need);

	assign last_row = (RCNT_W'(row_q) == rows_q - RCNT_W'(1));
	assign last_col = (col_q == width_q - WIDTH_W'(1));
	assign fend     = last_row && last_col;
	assign q_data   = {fend, jitter[0], dst, src_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_ROWS;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FE_ROWS: begin
				if (rows_done) begin
					state_d = FE_CLEAR;
				end
			end
			FE_CLEAR: begin
				if (clear_done) begin
					state_d = FE_RUN;
				end
			end
			FE_RUN: begin
				state_d = FE_RUN;
			end
			default: begin
				state_d = FE_ROWS;
			end
		endcase
		if (cfg_hit) begin
			state_d = FE_ROWS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_GRID_WIDTH;
			height_q <= RST_GRID_HEIGHT;
			rcnt_q   <= '0;
			rows_q   <= '0;
			acc_q    <= '0;
			base_q   <= '0;
			cnt_q    <= '0;
			col_q    <= '0;
			row_q    <= ROW_W'(1);
			src_q    <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == REG_GRID_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data[HEIGHT_W-1:0];
			end
			rcnt_q <= '0;
			acc_q  <= '0;
		end else begin
			case (state_q)
				FE_ROWS: begin
					if (rows_done) begin
						rows_q <= (width_q == '0) ? '0 : rcnt_q;
						base_q <= acc_q - CW'(width_q);
						cnt_q  <= '0;
						col_q  <= '0;
						row_q  <= ROW_W'(1);
						src_q  <= AW'(width_q);
					end else begin
						rcnt_q <= rcnt_q + RCNT_W'(1);
						acc_q  <= CW'(acc_nx);
					end
				end
				FE_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
				end
				FE_RUN: begin
					if (q_push) begin
						if (last_row) begin
							row_q <= ROW_W'(1);
							if (last_col) begin
								col_q <= '0;
								src_q <= AW'(width_q);
							end else begin
								col_q <= col_q + WIDTH_W'(1);
								src_q <= AW'(XW'(width_q) + XW'(col_q) + XW'(1));
							end
						end else begin
							row_q <= row_q + ROW_W'(1);
							src_q <= AW'(XW'(src_q) + XW'(width_q));
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== design/fecu_back.sv =====
// ----------------------------------------------------------------------------
// Fire effect cell update back end
// Owns the heat map memory, performs the read, decay and write of each cell
// update and hands the destination and source cells out as two items.
// ----------------------------------------------------------------------------
module fecu_back import fecu_pkg::*; #(
	parameter  int HEAT_LEVELS = DEF_HEAT_LEVELS,
	parameter  int MAX_CELLS   = DEF_MAX_CELLS,
	localparam int AW          = $clog2(MAX_CELLS),
	localparam int EW          = 2 * AW + 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  logic [EW-1:0]      q_data,
	output logic               q_pop,
	input  logic               clr_we,
	input  logic [AW-1:0]      clr_addr,
	input  logic               clr_hot,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   cell_index,
	output logic [GLYPH_W-1:0] glyph,
	output logic [COLOR_W-1:0] fg_color,
	output logic [COLOR_W-1:0] bg_color,
	output logic               pair_last,
	output logic               frame_end
);

	localparam logic [HEAT_W-1:0] TOP = HEAT_W'(HEAT_LEVELS - 1);

	logic [HEAT_W-1:0] heat_mem [MAX_CELLS];
	logic [HEAT_W-1:0] rdata_q;

	logic [AW-1:0]     q_src;
	logic [AW-1:0]     q_dst;
	logic              q_decay;
	logic              q_fend;

	logic              valid_s1;
	logic [AW-1:0]     src_s1;
	logic [AW-1:0]     dst_s1;
	logic              decay_s1;
	logic              fend_s1;
	logic              fwd_s1;
	logic [HEAT_W-1:0] fwdh_q;

	logic              ovalid_q;
	logic              osecond_q;
	logic [AW-1:0]     osrc_q;
	logic [AW-1:0]     odst_q;
	logic [HEAT_W-1:0] ovsrc_q;
	logic [HEAT_W-1:0] ovdst_q;
	logic              ofend_q;

	logic [HEAT_W-1:0] heat_s1;
	logic [HEAT_W-1:0] dec_s1;
	logic [HEAT_W-1:0] v_s1;
	logic              out_fire;
	logic              pair_free;
	logic              s1_adv;
	logic              issue;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [HEAT_W-1:0] mem_wdata;
	logic [HEAT_W-1:0] heat_o;

	assign q_src   = q_data[AW-1:0];
	assign q_dst   = q_data[2*AW-1:AW];
	assign q_decay = q_data[2*AW];
	assign q_fend  = q_data[2*AW+1];

	assign out_fire  = ovalid_q && out_ready;
	assign pair_free = !ovalid_q || (out_fire && osecond_q);
	assign s1_adv    = valid_s1 && pair_free;
	assign issue     = q_valid && (!valid_s1 || s1_adv);
	assign q_pop     = issue;

	// A read issued in the cycle that writes the same cell sees the old
	// contents, so the new heat is carried across instead.
	assign heat_s1 = fwd_s1 ? fwdh_q : rdata_q;
	assign dec_s1  = (heat_s1 < HEAT_W'(decay_s1)) ? '0 : heat_s1 - HEAT_W'(decay_s1);
	assign v_s1    = (dec_s1 > TOP) ? '0 : dec_s1;

	assign mem_we    = clr_we || s1_adv;
	assign mem_waddr = clr_we ? clr_addr : dst_s1;
	assign mem_wdata = clr_we ? (clr_hot ? TOP : '0) : v_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heat_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_q <= heat_mem[q_src];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			src_s1   <= q_src;
			dst_s1   <= q_dst;
			decay_s1 <= q_decay;
			fend_s1  <= q_fend;
			fwdh_q   <= v_s1;
		end
		if (s1_adv) begin
			osrc_q  <= src_s1;
			odst_q  <= dst_s1;
			ovdst_q <= v_s1;
			ovsrc_q <= (dst_s1 == src_s1) ? v_s1 : heat_s1;
			ofend_q <= fend_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fwd_s1    <= 1'b0;
			ovalid_q  <= 1'b0;
			osecond_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= s1_adv && (q_src == dst_s1);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
				fwd_s1   <= 1'b0;
			end
			// A new pair loads only once the last item of the old one leaves.
			if (s1_adv) begin
				ovalid_q  <= 1'b1;
				osecond_q <= 1'b0;
			end else if (out_fire) begin
				if (osecond_q) begin
					ovalid_q  <= 1'b0;
					osecond_q <= 1'b0;
				end else begin
					osecond_q <= 1'b1;
				end
			end
		end
	end

	assign heat_o     = osecond_q ? ovsrc_q : ovdst_q;
	assign out_valid  = ovalid_q;
	assign cell_index = IDX_W'(osecond_q ? osrc_q : odst_q);
	assign glyph      = PAL_GLYPH[heat_o];
	assign fg_color   = PAL_FG[heat_o];
	assign bg_color   = PAL_BG[heat_o];
	assign pair_last  = osecond_q;
	assign frame_end  = ofend_q;

	a_dst_not_after_src: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (dst_s1 <= src_s1))
		else $error("destination cell lies after its source cell");

	a_second_follows_first: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !osecond_q) |=> (ovalid_q && osecond_q))
		else $error("source cell item did not follow the destination item");

	a_no_clear_collision: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |-> !clr_we)
		else $error("cell update collided with the seeding sweep");

	a_issue_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> valid_s1)
		else $error("issued cell update was lost");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forwarded heat without an item in the read stage");

endmodule

// ===== design/fire_effect_cell_update.sv =====
// ----------------------------------------------------------------------------
// Fire effect cell update
// Fire spread over a heat map, one source cell per input item, drawn as two
// palette-mapped cells per item.
// ----------------------------------------------------------------------------
// Usage. Each item on the slave stream carries a 2-bit jitter and moves the
// column-major scan by one source cell. For each item the master stream gives
// two items: the destination cell with its new heat, then the source cell,
// which is marked by tlast. tuser is high on both items of the pair that ends
// a full scan of the map.
// The configuration channel writes the grid width (index 0) or height
// (index 1); either write reseeds the map and restarts the scan. Other
// indexes are accepted and ignored. Write only while the block is idle.
// Path: an input item passes the queue, the read stage and the output
// register pair before its destination item appears.
// Throughput: the single output register pair hands out one item per cycle
// while m_tready is high and loads a new pair once its source item leaves.
// Reset and every width or height write start a seeding sequence: a count
// of the active rows, then a sweep over all MAX_CELLS cells that writes one
// heat map cell a cycle. s_tready stays low until the sweep ends.
// If the receiver stalls, one item is held in the output pair, one in the
// read stage and four wait in the queue before s_tready drops.
// With fewer than two active rows an input item is taken and dropped.
// ----------------------------------------------------------------------------
module fire_effect_cell_update import fecu_pkg::*; #(
	parameter int HEAT_LEVELS = DEF_HEAT_LEVELS,
	parameter int MAX_CELLS   = DEF_MAX_CELLS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input item stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // [1:0] jitter, [7:2] zero
	// Result item stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // [13:0] cell_index, [27:14] glyph,
	                                        // [31:28] fg_color, [35:32] bg_color,
	                                        // [39:36] zero
	output logic                  m_tlast,  // pair_last
	output logic                  m_tuser   // frame_end
);

	localparam int AW = $clog2(MAX_CELLS);
	localparam int EW = 2 * AW + 2;

	logic               q_push;
	logic [EW-1:0]      q_in;
	logic               q_full;
	logic               q_pop;
	logic               q_valid;
	logic [EW-1:0]      q_out;
	logic               clr_we;
	logic [AW-1:0]      clr_addr;
	logic               clr_hot;
	logic [IDX_W-1:0]   cell_index;
	logic [GLYPH_W-1:0] glyph;
	logic [COLOR_W-1:0] fg_color;
	logic [COLOR_W-1:0] bg_color;

	// Front end: registers, seeding sequencer and scan walk.
	fecu_front #(
		.MAX_CELLS (MAX_CELLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.jitter    (s_tdata[JIT_W-1:0]),
		.q_push    (q_push),
		.q_data    (q_in),
		.q_full    (q_full),
		.clr_we    (clr_we),
		.clr_addr  (clr_addr),
		.clr_hot   (clr_hot)
	);

	// Cell updates wait here so that a stalled receiver does not hold the
	// scan at once.
	fecu_queue #(
		.W     (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_out)
	);

	// Back end: heat map memory, decay and the output pair.
	fecu_back #(
		.HEAT_LEVELS (HEAT_LEVELS),
		.MAX_CELLS   (MAX_CELLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_out),
		.q_pop      (q_pop),
		.clr_we     (clr_we),
		.clr_addr   (clr_addr),
		.clr_hot    (clr_hot),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.cell_index (cell_index),
		.glyph      (glyph),
		.fg_color   (fg_color),
		.bg_color   (bg_color),
		.pair_last  (m_tlast),
		.frame_end  (m_tuser)
	);

	assign m_tdata = {4'b0000, bg_color, fg_color, glyph, cell_index};

endmodule
